// ----- src/window_min_max_mean_p95_unit_defines.svh -----
// Assertion macros shared by the window statistics unit.
`ifndef WINDOW_MIN_MAX_MEAN_P95_UNIT_DEFINES_SVH
`define WINDOW_MIN_MAX_MEAN_P95_UNIT_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define WMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wms assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define WMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wms assertion failed");

`endif

// ----- src/wms_pkg.sv -----
// Package: constants, types and helpers for the window statistics unit.
package wms_pkg;
  localparam int MaxSamples = 64;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int SumW       = 38;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RANK,
    ST_SEL,
    ST_DIV,
    ST_DONE
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // store an accepted word
    logic close;     // marks the window close; the datapath does not use it
    logic sel_init;  // start the selection scan
    logic sel_step;  // advance the selection scan
    logic div_init;  // start the divider
    logic div_step;  // advance the divider
    logic emit;      // present the result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sel_done;
    logic div_done;
  } stat_t;

  // Nearest rank index ceil(95n/100)-1. The rank equals n - floor(n/20);
  // take floor(n/20) as n * 3277 >> 16.
  function automatic logic [AddrW-1:0] p95_index(input logic [CntW-1:0] n);
    logic [CntW+11:0] q;
    logic [CntW-1:0]  r;
    begin
      q = {12'd0, n} * (CntW + 12)'(3277);
      r = n - CntW'(q >> 16);
      if (r == '0) r = CntW'(1);
      p95_index = AddrW'(r - CntW'(1));
    end
  endfunction
endpackage

// ----- src/wms_ctrl.sv -----
// Controller state machine for the window statistics unit.
`include "window_min_max_mean_p95_unit_defines.svh"
module wms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           last_i,
  input  wms_pkg::stat_t stat_i,
  output logic           busy_o,
  output wms_pkg::cmd_t  cmd_o
);
  wms_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= wms_pkg::ST_LOAD;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      wms_pkg::ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (last_i) state_d = wms_pkg::ST_RANK;
        end
      end
      wms_pkg::ST_RANK: begin
        cmd_o.close    = 1'b1;
        cmd_o.sel_init = 1'b1;
        cmd_o.div_init = 1'b1;
        state_d        = wms_pkg::ST_SEL;
      end
      wms_pkg::ST_SEL: begin
        cmd_o.sel_step = 1'b1;
        cmd_o.div_step = 1'b1;
        if (stat_i.sel_done) state_d = wms_pkg::ST_DIV;
      end
      wms_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = wms_pkg::ST_DONE;
      end
      wms_pkg::ST_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = wms_pkg::ST_LOAD;
      end
      default: state_d = wms_pkg::ST_LOAD;
    endcase
  end

  `WMS_ASSERT_IMP(a_load_idle, cmd_o.load, !busy_o)
  `WMS_ASSERT_NXT(a_done_back, state_q == wms_pkg::ST_DONE, state_q == wms_pkg::ST_LOAD)
  `WMS_ASSERT_NXT(a_last_closes, start_i && !busy_o && last_i, state_q == wms_pkg::ST_RANK)
endmodule

// ----- src/wms_datapath.sv -----
// Datapath: sample store, running stats, rank selection scan and divider.
`include "window_min_max_mean_p95_unit_defines.svh"
module wms_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wms_pkg::cmd_t             cmd_i,
  input  logic signed [31:0]        sample_i,
  output wms_pkg::stat_t            stat_o,
  output logic                      valid_o,
  output logic signed [31:0]        min_o,
  output logic signed [31:0]        max_o,
  output logic signed [31:0]        mean_o,
  output logic signed [31:0]        p95_o,
  output logic [6:0]                count_o,
  output logic                      ovf_o
);
  localparam int AW = wms_pkg::AddrW;
  localparam int CW = wms_pkg::CntW;
  localparam int SW = wms_pkg::SumW;

  logic signed [31:0] mem_q [wms_pkg::MaxSamples];
  logic [CW-1:0]      cnt_q;
  logic signed [SW-1:0] sum_q;
  logic signed [31:0] min_q, max_q;
  logic               ovf_q;

  // Selection: candidate i is the answer if #less <= k < #less + #equal.
  // Outer index walks candidates, inner index walks the store; one compare a cycle.
  logic [AW-1:0]      k_q, ci_q, ji_q;
  logic signed [31:0] cand_q, rd_q;
  logic [CW-1:0]      lt_q, eq_q;
  logic [CW-1:0]      lt_nx, eq_nx;
  logic [1:0]         ph_q;   // 0 fetch cand, 1 fetch first elem, 2 compare
  logic               seld_q;
  logic signed [31:0] p95_q;

  // Divider: restoring on magnitudes.
  logic [SW-1:0]      dvq_q, rem_q;
  logic [CW-1:0]      dvs_q;
  logic [5:0]         dcnt_q;
  logic               neg_q, divd_q;

  logic [AW-1:0] last_a;
  logic [SW:0]   trial;
  logic [SW-1:0] rem_sh;
  assign last_a = AW'(cnt_q - CW'(1));
  assign rem_sh = {rem_q[SW-2:0], dvq_q[SW-1]};
  assign trial  = {1'b0, rem_sh} - {{(SW+1-CW){1'b0}}, dvs_q};

  // Counts including the compare of this cycle.
  assign lt_nx = lt_q + CW'(rd_q < cand_q);
  assign eq_nx = eq_q + CW'(rd_q == cand_q);

  // Store: write on load while not full, registered read.
  logic [AW-1:0] ra;
  always_comb begin
    ra = ji_q;
    if (ph_q == 2'd0) ra = ci_q;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && cnt_q != CW'(wms_pkg::MaxSamples)) mem_q[cnt_q[AW-1:0]] <= sample_i;
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sum_q <= '0; ovf_q <= 1'b0;
      min_q <= 32'sh7fffffff; max_q <= 32'sh80000000;
      seld_q <= 1'b0; divd_q <= 1'b0; valid_o <= 1'b0; ph_q <= '0;
    end else begin
      valid_o <= cmd_i.emit;
      if (cmd_i.load) begin
        if (cnt_q != CW'(wms_pkg::MaxSamples)) begin
          cnt_q <= cnt_q + CW'(1);
          sum_q <= sum_q + SW'(sample_i);
          if (sample_i < min_q) min_q <= sample_i;
          if (sample_i > max_q) max_q <= sample_i;
        end else ovf_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        cnt_q <= '0; sum_q <= '0; ovf_q <= 1'b0;
        min_q <= 32'sh7fffffff; max_q <= 32'sh80000000;
      end
      if (cmd_i.sel_init) begin
        seld_q <= 1'b0; ph_q <= 2'd0; ci_q <= '0; ji_q <= '0;
        k_q <= wms_pkg::p95_index(cnt_q);
      end else if (cmd_i.sel_step && !seld_q) begin
        case (ph_q)
          2'd0: begin ph_q <= 2'd1; ji_q <= '0; end
          2'd1: begin
            cand_q <= rd_q; ph_q <= 2'd2; lt_q <= '0; eq_q <= '0;
            ji_q <= ji_q + AW'(1);
          end
          default: begin
            lt_q <= lt_nx;
            eq_q <= eq_nx;
            ji_q <= ji_q + AW'(1);
            // ji wraps to zero past the last entry of a full store.
            if (ji_q == last_a + AW'(1)) begin
              if ((CW+1)'(k_q) >= (CW+1)'(lt_nx) &&
                  (CW+1)'(k_q) < (CW+1)'(lt_nx) + (CW+1)'(eq_nx)) begin
                p95_q <= cand_q; seld_q <= 1'b1;
              end else begin
                ci_q <= ci_q + AW'(1); ph_q <= 2'd0;
              end
            end
          end
        endcase
      end
      if (cmd_i.div_init) begin
        neg_q  <= sum_q[SW-1];
        dvq_q  <= sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
        dvs_q  <= cnt_q; rem_q <= '0; dcnt_q <= '0; divd_q <= 1'b0;
      end else if (cmd_i.div_step && !divd_q) begin
        if (!trial[SW]) begin
          rem_q <= trial[SW-1:0];
          dvq_q <= {dvq_q[SW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          dvq_q <= {dvq_q[SW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'(SW - 1)) divd_q <= 1'b1;
      end
    end
  end

  // In the compare phase rd_q holds the element at ji_q-1.
  assign stat_o.sel_done = seld_q;
  assign stat_o.div_done = divd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      min_o   <= min_q;
      max_o   <= max_q;
      mean_o  <= neg_q ? 32'(-dvq_q) : dvq_q[31:0];
      p95_o   <= p95_q;
      count_o <= 7'(cnt_q);
      ovf_o   <= ovf_q;
    end
  end

  `WMS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(wms_pkg::MaxSamples))
  `WMS_ASSERT_IMP(a_emit_done, cmd_i.emit, seld_q && divd_q)
  `WMS_ASSERT_NXT(a_valid_pulse, valid_o, !valid_o)
endmodule

// ----- src/window_min_max_mean_p95_unit.sv -----
// Top level of the window statistics unit: min, max, mean and 95th percentile.
//  channel  | handshake      | words
//  sample   | start/busy     | sample_value_i, last_sample_i
//  result   | valid_o        | min/max/mean/p95 value, sample_count, overflowed
// Samples load one per cycle while busy is low.
// After the last sample, the selection scan compares each candidate with the store
// (one compare a cycle over the store's single read port); the 38-step divider
// runs alongside it, and the result is emitted once both have finished.
// Reset clears counters and running stats; the store needs no clearing.
// The receiver cannot stall: valid_o is high for one cycle per window.
`include "window_min_max_mean_p95_unit_defines.svh"
module window_min_max_mean_p95_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] sample_value_i,
  input  logic               last_sample_i,
  output logic               valid_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] max_value_o,
  output logic signed [31:0] mean_value_o,
  output logic signed [31:0] p95_value_o,
  output logic [6:0]         sample_count_o,
  output logic               overflowed_o
);
  wms_pkg::cmd_t  cmd;
  wms_pkg::stat_t stat;

  wms_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .last_i(last_sample_i),
    .stat_i(stat), .busy_o(busy), .cmd_o(cmd)
  );

  wms_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sample_i(sample_value_i), .stat_o(stat),
    .valid_o, .min_o(min_value_o), .max_o(max_value_o), .mean_o(mean_value_o),
    .p95_o(p95_value_o), .count_o(sample_count_o), .ovf_o(overflowed_o)
  );

  `WMS_ASSERT_NXT(a_busy_after_last, start && !busy && last_sample_i, busy)
  `WMS_ASSERT_IMP(a_no_valid_idle, valid_o, !busy)
  `WMS_ASSERT_IMP(a_count_pos, valid_o, sample_count_o != 7'd0)
endmodule
